FILE: rtl/ppgwa_pkg.sv
// Shared types and constants for the optical sensor window average block.
// No dependencies; every other file refers to this package by scoped names.
package ppgwa_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int FRAME_W    = 3 * SAMPLE_W;
    localparam int VALUE_W    = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int GAIN_W     = 13;

    // operating mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_RATIO = 2'd1;
    localparam logic [1:0] MODE_LEAK  = 2'd2;
    localparam logic [1:0] MODE_NOISE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd2;

    localparam logic [7:0] WARMUP_RESET  = 8'd30;
    localparam logic [7:0] DIVIDER_RESET = 8'd25;

    // mid scale of a raw sample and the two report gains
    localparam logic [SAMPLE_W-1:0] MID_SCALE  = 24'h800000;
    localparam logic [GAIN_W-1:0]   GAIN_RATIO = 13'd4500;
    localparam logic [GAIN_W-1:0]   GAIN_LEAK  = 13'd450;

    // report request from the window control into the scaling pipeline
    typedef struct packed {
        logic valid;
        logic kind;
    } t_rep_req;

    // occupancy of the scaling pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_stat;

endpackage

FILE: rtl/ppgwa_ring.sv
// Frame ring memory: one write port, one registered read port with write bypass.
// Depends on ppgwa_pkg for the frame width.
module ppgwa_ring #(
    parameter int DEPTH = 80,
    parameter int AW    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [ppgwa_pkg::FRAME_W-1:0] i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [ppgwa_pkg::FRAME_W-1:0] o_rd_data
);

    logic [ppgwa_pkg::FRAME_W-1:0] r_mem [DEPTH];
    logic [ppgwa_pkg::FRAME_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port; a same-cycle write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ppgwa_ctrl.sv
// Configuration registers, warm-up drop, ring pointers, running sums and
// report decimation. Depends on ppgwa_pkg; drives ppgwa_ring and ppgwa_scale.
module ppgwa_ctrl #(
    parameter int WINDOW = 80,
    parameter int AW     = 7,
    parameter int FW     = 7,
    parameter int SUM_W  = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppgwa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppgwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]   i_sample_green,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]   i_sample_ir,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]   i_sample_red,
    input  logic                             i_batch_end,
    output logic                             o_in_stall,
    input  logic                             i_s1_ready,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [ppgwa_pkg::FRAME_W-1:0]    o_wr_data,
    output logic [AW-1:0]                    o_rd_addr,
    input  logic [ppgwa_pkg::FRAME_W-1:0]    i_rd_data,
    output ppgwa_pkg::t_rep_req              o_req,
    output logic [SUM_W-1:0]                 o_sum_green,
    output logic [SUM_W-1:0]                 o_sum_ir,
    output logic [SUM_W-1:0]                 o_sum_red
);

    localparam int SW = ppgwa_pkg::SAMPLE_W;

    logic [1:0]       r_mode,    n_mode;
    logic [7:0]       r_warmup,  n_warmup;
    logic [7:0]       r_div,     n_div;
    logic [7:0]       r_drop,    n_drop;
    logic [7:0]       r_phase,   n_phase;
    logic [AW-1:0]    r_wpos,    n_wpos;
    logic [FW-1:0]    r_fill,    n_fill;
    logic [SUM_W-1:0] r_sum_g,   n_sum_g;
    logic [SUM_W-1:0] r_sum_ir,  n_sum_ir;
    logic [SUM_W-1:0] r_sum_r,   n_sum_r;

    logic       accept;
    logic       active;
    logic       store;
    logic       full;
    logic       step;
    logic [7:0] div_eff;
    logic [8:0] phase_inc;
    logic [SUM_W-1:0] ev_g, ev_ir, ev_r;

    assign accept = i_in_valid && i_s1_ready;
    assign active = accept && (r_mode != ppgwa_pkg::MODE_OFF);
    assign store  = active && (r_drop == 8'd0);
    assign full   = (r_fill == FW'(WINDOW));

    // evicted frame, only subtracted once the ring is full
    assign ev_g  = full ? SUM_W'(i_rd_data[3*SW-1:2*SW]) : '0;
    assign ev_ir = full ? SUM_W'(i_rd_data[2*SW-1:SW])   : '0;
    assign ev_r  = full ? SUM_W'(i_rd_data[SW-1:0])      : '0;

    assign div_eff   = (r_div == 8'd0) ? 8'd1 : r_div;
    assign phase_inc = {1'b0, r_phase} + 9'd1;

    // item processing, then configuration writes
    always_comb begin
        n_mode   = r_mode;
        n_warmup = r_warmup;
        n_div    = r_div;
        n_drop   = r_drop;
        n_phase  = r_phase;
        n_wpos   = r_wpos;
        n_fill   = r_fill;
        n_sum_g  = r_sum_g;
        n_sum_ir = r_sum_ir;
        n_sum_r  = r_sum_r;
        step     = 1'b0;
        o_req    = '0;

        if (active && (r_drop != 8'd0)) begin
            n_drop = r_drop - 8'd1;
        end

        if (store) begin
            n_sum_g  = r_sum_g  - ev_g  + SUM_W'(i_sample_green);
            n_sum_ir = r_sum_ir - ev_ir + SUM_W'(i_sample_ir);
            n_sum_r  = r_sum_r  - ev_r  + SUM_W'(i_sample_red);
            n_wpos   = (r_wpos == AW'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
            n_fill   = full ? r_fill : r_fill + 1'b1;
        end

        // decimation on batch end with a full ring
        step = active && i_batch_end && (n_fill == FW'(WINDOW));
        if (step) begin
            n_phase = (phase_inc >= {1'b0, div_eff}) ? 8'd0 : phase_inc[7:0];
            o_req.valid = (r_phase == 8'd0) && (r_mode != ppgwa_pkg::MODE_NOISE);
            o_req.kind  = (r_mode == ppgwa_pkg::MODE_LEAK);
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                ppgwa_pkg::REG_OP_MODE: begin
                    n_mode   = i_cfg_data[1:0];
                    n_sum_g  = '0;
                    n_sum_ir = '0;
                    n_sum_r  = '0;
                    n_wpos   = '0;
                    n_fill   = '0;
                    n_drop   = r_warmup;
                end
                ppgwa_pkg::REG_WARMUP: begin
                    n_warmup = i_cfg_data;
                end
                ppgwa_pkg::REG_DIVIDER: begin
                    n_div = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ppgwa_pkg::MODE_OFF;
            r_warmup <= ppgwa_pkg::WARMUP_RESET;
            r_div    <= ppgwa_pkg::DIVIDER_RESET;
            r_drop   <= ppgwa_pkg::WARMUP_RESET;
            r_phase  <= 8'd0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_sum_g  <= '0;
            r_sum_ir <= '0;
            r_sum_r  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_warmup <= n_warmup;
            r_div    <= n_div;
            r_drop   <= n_drop;
            r_phase  <= n_phase;
            r_wpos   <= n_wpos;
            r_fill   <= n_fill;
            r_sum_g  <= n_sum_g;
            r_sum_ir <= n_sum_ir;
            r_sum_r  <= n_sum_r;
        end
    end

    // ring: write at the current slot, prefetch the next slot to be evicted
    assign o_wr_en   = store;
    assign o_wr_addr = r_wpos;
    assign o_wr_data = {i_sample_green, i_sample_ir, i_sample_red};
    assign o_rd_addr = n_wpos;

    assign o_sum_green = n_sum_g;
    assign o_sum_ir    = n_sum_ir;
    assign o_sum_red   = n_sum_r;
    assign o_in_stall  = !i_s1_ready;

endmodule

FILE: rtl/ppgwa_scale.sv
// Report pipeline: sum / WINDOW by reciprocal multiply with correction, then
// gain scaling to signed Q.8, with an output register. Depends on ppgwa_pkg.
module ppgwa_scale #(
    parameter int WINDOW = 80,
    parameter int SUM_W  = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ppgwa_pkg::t_rep_req                    i_req,
    input  logic [SUM_W-1:0]                       i_sum_green,
    input  logic [SUM_W-1:0]                       i_sum_ir,
    input  logic [SUM_W-1:0]                       i_sum_red,
    output logic                                   o_s1_ready,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_report_kind,
    output logic signed [ppgwa_pkg::VALUE_W-1:0]   o_green_value,
    output logic signed [ppgwa_pkg::VALUE_W-1:0]   o_ir_value,
    output logic signed [ppgwa_pkg::VALUE_W-1:0]   o_red_value,
    output ppgwa_pkg::t_pipe_stat                  o_stat
);

    localparam int SW     = ppgwa_pkg::SAMPLE_W;
    localparam int VW     = ppgwa_pkg::VALUE_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int D_W    = SW + 1;
    localparam int G_W    = ppgwa_pkg::GAIN_W + 1;
    localparam int X_W    = D_W + G_W;
    localparam int Q_SH   = 15;
    // floor(2^SUM_W / WINDOW): estimate is exact or one low for any sum
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / WINDOW);

    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic r_k1, r_k2, r_k3, r_k4, r_ok;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [SUM_W-1:0]      r_sum1 [3];
    logic [SUM_W-1:0]      r_sum2 [3];
    logic [PROD_W-1:0]     r_prod [3];
    logic [SW-1:0]         r_avg  [3];
    logic signed [X_W-1:0] r_x    [3];
    logic signed [VW-1:0]  r_val  [3];

    logic [SUM_W-1:0]      sum_in [3];
    logic [PROD_W-1:0]     prod   [3];
    logic [SW-1:0]         q_est  [3];
    logic [SUM_W:0]        qw     [3];
    logic [SUM_W:0]        rem    [3];
    logic [SW-1:0]         avg    [3];
    logic signed [D_W-1:0] dev    [3];
    logic signed [X_W-1:0] xval   [3];
    logic signed [G_W-1:0] gain;

    // stage handshake: a stage loads when empty or when it moves on
    assign rdy5 = !r_ov || !i_out_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign sum_in[0] = i_sum_green;
    assign sum_in[1] = i_sum_ir;
    assign sum_in[2] = i_sum_red;

    assign gain = r_k3 ? $signed({1'b0, ppgwa_pkg::GAIN_LEAK})
                       : $signed({1'b0, ppgwa_pkg::GAIN_RATIO});

    // per-channel datapath between stages
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]  = PROD_W'(r_sum1[c]) * PROD_W'(RECIP);
            q_est[c] = r_prod[c][SUM_W +: SW];
            qw[c]    = (SUM_W + 1)'(q_est[c]) * (SUM_W + 1)'(WINDOW);
            rem[c]   = {1'b0, r_sum2[c]} - qw[c];
            avg[c]   = (rem[c] >= (SUM_W + 1)'(WINDOW)) ? q_est[c] + 1'b1 : q_est[c];
            dev[c]   = $signed({1'b0, r_avg[c]}) - $signed({1'b0, ppgwa_pkg::MID_SCALE});
            xval[c]  = X_W'(dev[c]) * X_W'(gain);
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_req.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_ov <= r_v4;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_req.valid) begin
            r_k1 <= i_req.kind;
            for (int c = 0; c < 3; c++) r_sum1[c] <= sum_in[c];
        end
        if (rdy2 && r_v1) begin
            r_k2 <= r_k1;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= prod[c];
                r_sum2[c] <= r_sum1[c];
            end
        end
        if (rdy3 && r_v2) begin
            r_k3 <= r_k2;
            for (int c = 0; c < 3; c++) r_avg[c] <= avg[c];
        end
        if (rdy4 && r_v3) begin
            r_k4 <= r_k3;
            for (int c = 0; c < 3; c++) r_x[c] <= xval[c];
        end
        // floor division by 2^15 is the bit slice of the two's complement product
        if (rdy5 && r_v4) begin
            r_ok <= r_k4;
            for (int c = 0; c < 3; c++) r_val[c] <= r_x[c][Q_SH +: VW];
        end
    end

    assign o_s1_ready    = rdy1;
    assign o_out_valid   = r_ov;
    assign o_report_kind = r_ok;
    assign o_green_value = r_val[0];
    assign o_ir_value    = r_val[1];
    assign o_red_value   = r_val[2];
    assign o_stat        = '{s1: r_v1, s2: r_v2, s3: r_v3, s4: r_v4};

endmodule

FILE: rtl/ppg_window_average_test_top.sv
// Top level of the optical sensor window average with decimated reports.
// Depends on ppgwa_pkg, ppgwa_ring, ppgwa_ctrl and ppgwa_scale.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_sample_green/ir/red, i_batch_end
//   output    out        o_out_valid / i_out_stall o_report_kind, o_green/ir/red_value
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One frame is taken per cycle while o_in_stall is low; the ring read of the slot
// to be evicted is prefetched, so sums and ring are updated in the cycle of the frame.
// A report passes the registers for sums, reciprocal multiply, correction, gain
// multiply and output in that order. Frames without a report occupy no stage.
// o_in_stall rises only when the first report stage is held by a stalled output.
// Synchronous active-low reset; the ring contents are not cleared.
module ppg_window_average_test_top #(
    parameter int WINDOW = 80
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ppgwa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppgwa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]       i_sample_green,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]       i_sample_ir,
    input  logic [ppgwa_pkg::SAMPLE_W-1:0]       i_sample_red,
    input  logic                                 i_batch_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_report_kind,
    output logic signed [ppgwa_pkg::VALUE_W-1:0] o_green_value,
    output logic signed [ppgwa_pkg::VALUE_W-1:0] o_ir_value,
    output logic signed [ppgwa_pkg::VALUE_W-1:0] o_red_value
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int SUM_W = ppgwa_pkg::SAMPLE_W + $clog2(WINDOW);

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [ppgwa_pkg::FRAME_W-1:0] wr_data;
    logic [ppgwa_pkg::FRAME_W-1:0] rd_data;
    logic                          s1_ready;
    logic [SUM_W-1:0]              sum_green, sum_ir, sum_red;
    ppgwa_pkg::t_rep_req           req;
    ppgwa_pkg::t_pipe_stat         stat;

    ppgwa_ring #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ppgwa_ctrl #(
        .WINDOW (WINDOW),
        .AW     (AW),
        .FW     (FW),
        .SUM_W  (SUM_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_sample_green (i_sample_green),
        .i_sample_ir    (i_sample_ir),
        .i_sample_red   (i_sample_red),
        .i_batch_end    (i_batch_end),
        .o_in_stall     (o_in_stall),
        .i_s1_ready     (s1_ready),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_req          (req),
        .o_sum_green    (sum_green),
        .o_sum_ir       (sum_ir),
        .o_sum_red      (sum_red)
    );

    ppgwa_scale #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_sum_green   (sum_green),
        .i_sum_ir      (sum_ir),
        .i_sum_red     (sum_red),
        .o_s1_ready    (s1_ready),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_report_kind (o_report_kind),
        .o_green_value (o_green_value),
        .o_ir_value    (o_ir_value),
        .o_red_value   (o_red_value),
        .o_stat        (stat)
    );

`ifndef SYNTHESIS
    // a report request only issues on a transfer, so never under stall
    a_req_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid |-> !o_in_stall)
        else $error("report request issued while input stalled");

    // a request lands in the first report stage
    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid |=> stat.s1)
        else $error("report request lost at first stage");

    // a new result comes only from the last pipeline stage
    a_out_from_s4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stat.s4))
        else $error("result appeared without a pending report");

    // input stalls only while the first stage is occupied
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.s1 |-> !o_in_stall)
        else $error("input stalled with empty first stage");
`endif

endmodule

FILE: tb/tb_ppg_window_average_test_top.sv
// Self-checking testbench for ppg_window_average_test_top: directed and random frames
// through the sliding window, with reports predicted in-bench and compared field by field.
// Depends on ppgwa_pkg and the RTL top level only.
module tb_ppg_window_average_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = ppgwa_pkg::SAMPLE_W;
    localparam int VALUE_W    = ppgwa_pkg::VALUE_W;
    localparam int CFG_IDX_W  = ppgwa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ppgwa_pkg::CFG_DATA_W;

    localparam int WINDOW         = 80;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TARGET_FRAMES  = 1050;
    localparam int TARGET_REPORTS = 40;
    localparam int MAX_SEGMENTS   = 40;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // sample content styles for a random segment
    localparam int STY_UNIFORM = 0;
    localparam int STY_MAX     = 1;
    localparam int STY_ZERO    = 2;
    localparam int STY_MID     = 3;
    localparam int STY_RAILS   = 4;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] MID_SCALE  = ppgwa_pkg::MID_SCALE;

    typedef struct packed {
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] ir;
        logic [SAMPLE_W-1:0] red;
        logic                last;
        logic                hold;   // wait for all reports before this transfer
    } t_frame;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] green;
        logic [VALUE_W-1:0] ir;
        logic [VALUE_W-1:0] red;
    } t_report;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = ppgwa_pkg::REG_OP_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample_green = '0;
    logic [SAMPLE_W-1:0]   i_sample_ir = '0;
    logic [SAMPLE_W-1:0]   i_sample_red = '0;
    logic                  i_batch_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_report_kind;
    logic signed [VALUE_W-1:0] o_green_value;
    logic signed [VALUE_W-1:0] o_ir_value;
    logic signed [VALUE_W-1:0] o_red_value;

    ppg_window_average_test_top #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_green (i_sample_green),
        .i_sample_ir    (i_sample_ir),
        .i_sample_red   (i_sample_red),
        .i_batch_end    (i_batch_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_kind  (o_report_kind),
        .o_green_value  (o_green_value),
        .o_ir_value     (o_ir_value),
        .o_red_value    (o_red_value)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // stimulus and expectation stores
    t_frame  frame_q[$];
    t_report pending_reports[$];
    t_frame  next_frame;
    t_report want, got;
    logic    frame_taken = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      fail_count = 0;
    int      reports_due = 0;
    int      quiet_cycles = 0;

    // predictor state: mirrors the block's window and control registers
    logic [SAMPLE_W-1:0] ring_mem [WINDOW][3];
    logic [30:0]         chan_sum [3];
    int                  wr_pos = 0;
    int                  fill_cnt = 0;
    int                  phase_cnt = 0;
    logic [1:0]          cur_mode = ppgwa_pkg::MODE_OFF;
    logic [7:0]          warmup_reg = ppgwa_pkg::WARMUP_RESET;
    logic [7:0]          divider_reg = ppgwa_pkg::DIVIDER_RESET;
    logic [7:0]          drop_left = ppgwa_pkg::WARMUP_RESET;

    function automatic void clear_window();
        for (int c = 0; c < 3; c++) chan_sum[c] = '0;
        wr_pos = 0;
        fill_cnt = 0;
    endfunction

    // floor(sum/WINDOW) re-centered and scaled to Q.8, floor rounding
    function automatic logic [VALUE_W-1:0] scale_avg(input logic [30:0] sum,
                                                     input logic leak);
        longint avg;
        longint gain;
        longint prod;
        gain = leak ? longint'(ppgwa_pkg::GAIN_LEAK) : longint'(ppgwa_pkg::GAIN_RATIO);
        avg = longint'(sum) / WINDOW;
        prod = (avg - longint'(MID_SCALE)) * gain;
        prod = prod >>> 15;
        return prod[VALUE_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            ppgwa_pkg::REG_OP_MODE: begin
                cur_mode = val[1:0];
                clear_window();
                drop_left = warmup_reg;
            end
            ppgwa_pkg::REG_WARMUP:  warmup_reg = val;
            ppgwa_pkg::REG_DIVIDER: divider_reg = val;
            default: ;
        endcase
    endfunction

    // one accepted frame: update window, decide on a report
    function automatic void average_frame(input logic [SAMPLE_W-1:0] g,
                                          input logic [SAMPLE_W-1:0] ir,
                                          input logic [SAMPLE_W-1:0] r,
                                          input logic last);
        logic [SAMPLE_W-1:0] smp [3];
        int      div_eff;
        logic    due;
        t_report rep;
        smp[0] = g;
        smp[1] = ir;
        smp[2] = r;
        if (cur_mode == ppgwa_pkg::MODE_OFF) return;
        if (drop_left != 0) begin
            drop_left--;
        end else begin
            for (int c = 0; c < 3; c++) begin
                if (fill_cnt >= WINDOW)
                    chan_sum[c] = chan_sum[c] - 31'(ring_mem[wr_pos][c]);
                chan_sum[c] = chan_sum[c] + 31'(smp[c]);
                ring_mem[wr_pos][c] = smp[c];
            end
            wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
            if (fill_cnt < WINDOW) fill_cnt++;
        end
        if (!last || fill_cnt < WINDOW) return;
        div_eff = (divider_reg == 0) ? 1 : int'(divider_reg);
        due = (phase_cnt == 0);
        phase_cnt++;
        if (phase_cnt >= div_eff) phase_cnt = 0;
        if (!due || cur_mode == ppgwa_pkg::MODE_NOISE) return;
        rep.kind  = (cur_mode == ppgwa_pkg::MODE_LEAK);
        rep.green = scale_avg(chan_sum[0], rep.kind);
        rep.ir    = scale_avg(chan_sum[1], rep.kind);
        rep.red   = scale_avg(chan_sum[2], rep.kind);
        pending_reports.push_back(rep);
        reports_due++;
    endfunction

    // driver: new transfer only once the current one is gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || frame_taken) begin
            if (frame_q.size() != 0 && !(frame_q[0].hold && pending_reports.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                next_frame = frame_q.pop_front();
                i_in_valid     <= 1'b1;
                i_sample_green <= next_frame.green;
                i_sample_ir    <= next_frame.ir;
                i_sample_red   <= next_frame.red;
                i_batch_end    <= next_frame.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        frame_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            average_frame(i_sample_green, i_sample_ir, i_sample_red, i_batch_end);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_report_kind, o_green_value, o_ir_value, o_red_value};
            if (pending_reports.size() == 0) begin
                if (fail_count < 10)
                    $display("ERROR %0t: unexpected report kind=%0d g=%0d ir=%0d r=%0d",
                             $realtime, got.kind, $signed(got.green), $signed(got.ir),
                             $signed(got.red));
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got != want) begin
                    if (fail_count < 10) begin
                        $display("ERROR %0t: report exp kind=%0d g=%0d ir=%0d r=%0d",
                                 $realtime, want.kind, $signed(want.green),
                                 $signed(want.ir), $signed(want.red));
                        $display("       got kind=%0d g=%0d ir=%0d r=%0d",
                                 got.kind, $signed(got.green), $signed(got.ir),
                                 $signed(got.red));
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ppg_window_average_test_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, val);
    endtask

    // all frames sent, all reports back, pipeline drained
    task automatic wait_quiet();
        while (frame_q.size() != 0 || i_in_valid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_frame(input logic [SAMPLE_W-1:0] g,
                                       input logic [SAMPLE_W-1:0] ir,
                                       input logic [SAMPLE_W-1:0] r, input logic last,
                                       input logic hold);
        frame_q.push_back('{g, ir, r, last, hold});
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
        logic [SAMPLE_W-1:0] v;
        case (style)
            STY_MAX:   v = FULL_SCALE;
            STY_ZERO:  v = '0;
            STY_MID:   v = MID_SCALE - 24'd256 + SAMPLE_W'($urandom_range(511));
            STY_RAILS: v = $urandom_range(1) ? FULL_SCALE : '0;
            default:   v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    initial begin : stimulus
        int         seg, len, style, last_pct, items_sent;
        logic [1:0] seg_mode;
        logic       rewrite, prev_last, last, hold;
        logic [7:0] warm_val, div_val;

        items_sent = 0;
        clear_window();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: mode off ignores everything
        push_frame('0, '0, '0, 1'b1, 1'b0);
        push_frame(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1, 1'b0);
        push_frame(24'h123456, 24'hABCDEF, 24'h5A5A5A, 1'b0, 1'b0);
        wait_quiet();

        // spare index ignored; warm-up only takes effect on a mode write
        write_reg(REG_SPARE, 8'hFF);
        write_reg(ppgwa_pkg::REG_WARMUP, 8'd2);
        write_reg(ppgwa_pkg::REG_OP_MODE, {6'd0, ppgwa_pkg::MODE_RATIO});
        push_frame(FULL_SCALE, '0, MID_SCALE, 1'b1, 1'b0);
        push_frame('0, FULL_SCALE, MID_SCALE - 24'd1, 1'b1, 1'b0);
        push_frame(MID_SCALE, MID_SCALE - 24'd1, FULL_SCALE, 1'b1, 1'b0);
        push_frame(24'h000001, 24'hFFFFFE, 24'h7FFFFF, 1'b0, 1'b0);
        push_frame(24'hAAAAAA, 24'h555555, '0, 1'b1, 1'b0);
        push_frame(24'h555555, 24'hAAAAAA, FULL_SCALE, 1'b1, 1'b0);
        wait_quiet();

        // batch ends with the window not full: still no report
        write_reg(ppgwa_pkg::REG_WARMUP, 8'd0);
        push_frame(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1, 1'b0);
        push_frame('0, '0, '0, 1'b1, 1'b0);
        wait_quiet();

        // mode write of off also clears the window
        write_reg(ppgwa_pkg::REG_OP_MODE, {6'd0, ppgwa_pkg::MODE_OFF});
        push_frame(24'h0F0F0F, 24'hF0F0F0, 24'h00FF00, 1'b1, 1'b0);
        push_frame(24'hFF00FF, 24'h0000FF, 24'hFF0000, 1'b0, 1'b0);
        wait_quiet();
        // divider zero behaves as one; kept for the first random segment
        write_reg(ppgwa_pkg::REG_DIVIDER, 8'd0);

        // random segments, each under its own settings
        for (seg = 0;
             seg < MAX_SEGMENTS && (items_sent < TARGET_FRAMES || reports_due < TARGET_REPORTS);
             seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase

            if (seg == 3) rewrite = 1'b0;
            else if (seg < 3 || cur_mode == ppgwa_pkg::MODE_OFF) rewrite = 1'b1;
            else rewrite = ($urandom_range(9) < 7);

            case (seg)
                0, 2: seg_mode = ppgwa_pkg::MODE_RATIO;
                1: seg_mode = ppgwa_pkg::MODE_LEAK;
                default: begin
                    case ($urandom_range(15))
                        0: seg_mode = ppgwa_pkg::MODE_OFF;
                        1, 2: seg_mode = ppgwa_pkg::MODE_NOISE;
                        3, 4, 5, 6, 7, 8, 9: seg_mode = ppgwa_pkg::MODE_RATIO;
                        default: seg_mode = ppgwa_pkg::MODE_LEAK;
                    endcase
                end
            endcase

            warm_val = (seg == 1) ? 8'd255
                     : ($urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(12)));
            case (seg)
                2: div_val = 8'd255;
                3: div_val = 8'd1;
                default: div_val = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(6, 1));
            endcase

            // settings: divider and warm-up in random order, mode last
            if ($urandom_range(1)) begin
                if (seg != 0 && (seg < 4 || $urandom_range(4) != 0))
                    write_reg(ppgwa_pkg::REG_DIVIDER, div_val);
                if (rewrite || $urandom_range(1)) write_reg(ppgwa_pkg::REG_WARMUP, warm_val);
            end else begin
                if (rewrite || $urandom_range(1)) write_reg(ppgwa_pkg::REG_WARMUP, warm_val);
                if (seg != 0 && (seg < 4 || $urandom_range(4) != 0))
                    write_reg(ppgwa_pkg::REG_DIVIDER, div_val);
            end
            if (rewrite) write_reg(ppgwa_pkg::REG_OP_MODE, {6'd0, seg_mode});

            // segment shape: fill the window, then batches
            case ($urandom_range(9))
                0: style = STY_MAX;
                1: style = STY_ZERO;
                2: style = STY_MID;
                3: style = STY_RAILS;
                default: style = STY_UNIFORM;
            endcase
            case ($urandom_range(3))
                0: last_pct = 100;
                1: last_pct = 50;
                2: last_pct = 20;
                default: last_pct = 5;
            endcase
            if (cur_mode == ppgwa_pkg::MODE_OFF) len = 10;
            else if (rewrite) len = int'(drop_left) + WINDOW + int'($urandom_range(100, 10));
            else len = int'($urandom_range(100, 20));
            if (cur_mode != ppgwa_pkg::MODE_OFF) items_sent += len;

            prev_last = 1'b0;
            for (int k = 0; k < len; k++) begin
                last = ($urandom_range(99) < last_pct);
                hold = prev_last && (seg == 0 || $urandom_range(3) == 0);
                push_frame(pick_sample(style), pick_sample(style), pick_sample(style), last, hold);
                prev_last = last;
            end
            wait_quiet();
        end

        wait_quiet();
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("tb_ppg_window_average_test_top OK");
        end else begin
            $display("tb_ppg_window_average_test_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ppgwa_pkg.sv
rtl/ppgwa_ring.sv
rtl/ppgwa_ctrl.sv
rtl/ppgwa_scale.sv
rtl/ppg_window_average_test_top.sv
tb/tb_ppg_window_average_test_top.sv
